FILE: src/bit_assembling_byte_ring_buffer_defines.svh
// assertion macros used by the checker file
`ifndef BIT_ASSEMBLING_BYTE_RING_BUFFER_DEFINES_SVH
`define BIT_ASSEMBLING_BYTE_RING_BUFFER_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define BBRB_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define BBRB_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/bbrb_pkg.sv
// package with shared types and constants of the byte ring buffer
`default_nettype none

package bbrb_pkg;

    localparam int RING_DEPTH = 256;
    localparam int BYTE_W     = 8;
    localparam int CMD_W      = 3;
    localparam int IDLE_W     = 16;
    localparam int BITS_W     = 3;
    localparam int CLEN_W     = 9;
    localparam int FILL_W     = 8;
    localparam int PADDR_W    = 3;
    localparam int PDATA_W    = 32;

    localparam logic [IDLE_W-1:0]    IDLE_LIMIT_RST = IDLE_W'(100);
    localparam logic [IDLE_W-1:0]    TICK_MAX       = '1;
    localparam logic [BITS_W-1:0]    LAST_BIT       = BITS_W'(7);
    localparam logic [PADDR_W-3:0]   REG_IDLE_LIMIT = '0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD_BIT = 3'd0,
        CMD_PUSH    = 3'd1,
        CMD_POP     = 3'd2,
        CMD_TAKE    = 3'd3,
        CMD_PEEK    = 3'd4,
        CMD_TICK    = 3'd5,
        CMD_CLEAR   = 3'd6
    } cmd_t;

    typedef struct packed {
        logic [IDLE_W-1:0] idle_limit;
    } cfg_t;

endpackage

`default_nettype wire

FILE: src/bbrb_cmd_if.sv
// request channel interface of the byte ring buffer
`default_nettype none

interface bbrb_cmd_if
    import bbrb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] value_in;

    modport source (output valid, command, value_in, input ready);
    modport sink (input valid, command, value_in, output ready);
endinterface

`default_nettype wire

FILE: src/bbrb_res_if.sv
// result channel interface of the byte ring buffer
`default_nettype none

interface bbrb_res_if
    import bbrb_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] read_data;
    logic              read_valid;
    logic              dropped;
    logic [BYTE_W-1:0] chunk_start;
    logic [CLEN_W-1:0] chunk_length;
    logic [FILL_W-1:0] fill_count;
    logic [BITS_W-1:0] partial_bits;

    modport source (output valid, read_data, read_valid, dropped, chunk_start,
                    chunk_length, fill_count, partial_bits, input ready);
    modport sink (input valid, read_data, read_valid, dropped, chunk_start,
                  chunk_length, fill_count, partial_bits, output ready);
endinterface

`default_nettype wire

FILE: src/bbrb_ram.sv
// generic single-write single-read ram with registered read
`default_nettype none

module bbrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                    clk,
    input  wire logic                                    we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                        wdata,
    input  wire logic                                    re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output      logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: src/bbrb_cfg.sv
// apb configuration register block of the byte ring buffer
`default_nettype none

module bbrb_cfg
    import bbrb_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready,
    output      cfg_t               cfg
);

    logic [IDLE_W-1:0] idle_limit_reg;
    logic [IDLE_W-1:0] idle_limit_next;
    logic              hit;

    assign pready = 1'b1;
    assign hit    = (paddr[PADDR_W-1:2] == REG_IDLE_LIMIT);

    always_comb
    begin
        idle_limit_next = idle_limit_reg;
        if (psel && penable && pwrite && pready && hit)
        begin
            idle_limit_next = pwdata[IDLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_limit_reg <= IDLE_LIMIT_RST;
        end
        else
        begin
            idle_limit_reg <= idle_limit_next;
        end
    end

    assign prdata         = (psel && hit) ? PDATA_W'(idle_limit_reg) : '0;
    assign cfg.idle_limit = idle_limit_reg;

endmodule

`default_nettype wire

FILE: src/bit_assembling_byte_ring_buffer.sv
// top level of the bit-assembling byte ring buffer
// usage:
//   requests enter on cmd (valid/ready), each with a command and a value;
//   every request gives exactly one result on res (valid/ready).
//   add bit shifts bit 0 of value into the partial byte, lsb first, and the
//   eighth bit stores the byte; push, pop, take chunk, peek, tick and clear
//   partial work on the ring as their names say. the ring holds DEPTH-1 bytes
//   and a byte offered to a full ring is dropped and flagged. the user writes
//   idle_limit via the apb port only with no request in flight; unchecked.
// timing:
//   a request is accepted on cmd; the ring memory is read or written at
//   that edge and the request enters the result stage; the output register
//   then takes the registered read data when free, and res.valid rises.
//   one request per cycle is sustained while res takes results; each request
//   makes at most one ring access. if res stalls, the result stage and output
//   register fill and cmd.ready drops until the output is taken.
// reset:
//   indices, partial byte, bit count and idle counter clear, idle_limit goes
//   to 100; the ring contents are not cleared and need no clearing pass.
`default_nettype none

module bit_assembling_byte_ring_buffer
    import bbrb_pkg::*;
#(
    parameter int DEPTH = RING_DEPTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    bbrb_cmd_if.sink                cmd,
    bbrb_res_if.source              res,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = IDX_W + 1;
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(DEPTH);

    function automatic logic [IDX_W-1:0] advance(input logic [IDX_W-1:0] idx);
        return (idx == IDX_LAST) ? '0 : idx + 1'b1;
    endfunction

    cfg_t cfg;

    // ring state
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next;
    logic [BYTE_W-1:0] partial_reg, partial_next;
    logic [BITS_W-1:0] bits_reg, bits_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;

    // result stage
    logic              s2_valid_reg, s2_valid_next;
    logic              s2_rvalid_reg, s2_rvalid_next;
    logic              s2_drop_reg, s2_drop_next;
    logic [BYTE_W-1:0] s2_cstart_reg, s2_cstart_next;
    logic [CLEN_W-1:0] s2_clen_reg, s2_clen_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_rdata_reg;
    logic              out_rvalid_reg;
    logic              out_drop_reg;
    logic [BYTE_W-1:0] out_cstart_reg;
    logic [CLEN_W-1:0] out_clen_reg;
    logic [FILL_W-1:0] out_fill_reg;
    logic [BITS_W-1:0] out_bits_reg;

    logic              cmd_fire;
    logic              out_free;
    logic              s2_move;
    cmd_t              cmd_code;
    logic [BYTE_W-1:0] pb_set;
    logic [IDX_W-1:0]  adv_wr;
    logic [IDX_W-1:0]  adv_rd;
    logic              ring_full;
    logic [CNT_W-1:0]  fill_w;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_wdata;
    logic              ram_re;
    logic [BYTE_W-1:0] ram_rdata;

    bbrb_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bbrb_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wr_idx_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    assign out_free  = !out_valid_reg || res.ready;
    assign s2_move   = s2_valid_reg && out_free;
    assign cmd.ready = !s2_valid_reg || out_free;
    assign cmd_fire  = cmd.valid && cmd.ready;
    assign cmd_code  = cmd_t'(cmd.command);
    assign adv_wr    = advance(wr_idx_reg);
    assign adv_rd    = advance(rd_idx_reg);
    assign ring_full = (adv_wr == rd_idx_reg);

    always_comb
    begin
        pb_set           = partial_reg;
        pb_set[bits_reg] = partial_reg[bits_reg] | cmd.value_in[0];
    end

    // fill level of the ring as held in the registers
    always_comb
    begin
        if (wr_idx_reg >= rd_idx_reg)
        begin
            fill_w = {1'b0, wr_idx_reg} - {1'b0, rd_idx_reg};
        end
        else
        begin
            fill_w = DEPTH_C - {1'b0, rd_idx_reg} + {1'b0, wr_idx_reg};
        end
    end

    // request decode and state update
    always_comb
    begin
        wr_idx_next    = wr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        partial_next   = partial_reg;
        bits_next      = bits_reg;
        idle_next      = idle_reg;
        ram_we         = 1'b0;
        ram_wdata      = cmd.value_in;
        ram_re         = 1'b0;
        s2_rvalid_next = 1'b0;
        s2_drop_next   = 1'b0;
        s2_cstart_next = '0;
        s2_clen_next   = '0;
        if (cmd_fire)
        begin
            case (cmd_code)
                CMD_ADD_BIT:
                begin
                    idle_next = '0;
                    if (bits_reg == LAST_BIT)
                    begin
                        if (ring_full)
                        begin
                            s2_drop_next = 1'b1;
                        end
                        else
                        begin
                            ram_we      = 1'b1;
                            ram_wdata   = pb_set;
                            wr_idx_next = adv_wr;
                        end
                        partial_next = '0;
                        bits_next    = '0;
                    end
                    else
                    begin
                        partial_next = pb_set;
                        bits_next    = bits_reg + 1'b1;
                    end
                end
                CMD_PUSH:
                begin
                    if (ring_full)
                    begin
                        s2_drop_next = 1'b1;
                    end
                    else
                    begin
                        ram_we      = 1'b1;
                        wr_idx_next = adv_wr;
                    end
                end
                CMD_POP:
                begin
                    if (wr_idx_reg != rd_idx_reg)
                    begin
                        ram_re         = 1'b1;
                        s2_rvalid_next = 1'b1;
                        rd_idx_next    = adv_rd;
                    end
                end
                CMD_TAKE:
                begin
                    s2_cstart_next = BYTE_W'(rd_idx_reg);
                    // wrapped contents: take only up to the end of the ring
                    if (wr_idx_reg < rd_idx_reg)
                    begin
                        s2_clen_next = CLEN_W'(DEPTH_C - {1'b0, rd_idx_reg});
                        rd_idx_next  = '0;
                    end
                    else
                    begin
                        s2_clen_next = CLEN_W'({1'b0, wr_idx_reg} - {1'b0, rd_idx_reg});
                        rd_idx_next  = wr_idx_reg;
                    end
                end
                CMD_PEEK:
                begin
                    s2_cstart_next = BYTE_W'(rd_idx_reg);
                    // stale partial byte is thrown away
                    if ((idle_reg > cfg.idle_limit) && (bits_reg != '0))
                    begin
                        idle_next    = '0;
                        partial_next = '0;
                        bits_next    = '0;
                    end
                end
                CMD_TICK:
                begin
                    if ((bits_reg != '0) && (idle_reg != TICK_MAX))
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                end
                CMD_CLEAR:
                begin
                    partial_next = '0;
                    bits_next    = '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        if (cmd_fire)
        begin
            s2_valid_next = 1'b1;
        end
        else if (s2_move)
        begin
            s2_valid_next = 1'b0;
        end
        else
        begin
            s2_valid_next = s2_valid_reg;
        end
    end

    always_comb
    begin
        if (s2_move)
        begin
            out_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_idx_reg    <= '0;
            rd_idx_reg    <= '0;
            partial_reg   <= '0;
            bits_reg      <= '0;
            idle_reg      <= '0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            wr_idx_reg    <= wr_idx_next;
            rd_idx_reg    <= rd_idx_next;
            partial_reg   <= partial_next;
            bits_reg      <= bits_next;
            idle_reg      <= idle_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_fire)
        begin
            s2_rvalid_reg <= s2_rvalid_next;
            s2_drop_reg   <= s2_drop_next;
            s2_cstart_reg <= s2_cstart_next;
            s2_clen_reg   <= s2_clen_next;
        end
        // fill and bit count come from the registers, which hold the state
        // left by the request in the result stage
        if (s2_move)
        begin
            out_rdata_reg  <= s2_rvalid_reg ? ram_rdata : '0;
            out_rvalid_reg <= s2_rvalid_reg;
            out_drop_reg   <= s2_drop_reg;
            out_cstart_reg <= s2_cstart_reg;
            out_clen_reg   <= s2_clen_reg;
            out_fill_reg   <= FILL_W'(fill_w);
            out_bits_reg   <= bits_reg;
        end
    end

    assign res.valid        = out_valid_reg;
    assign res.read_data    = out_rdata_reg;
    assign res.read_valid   = out_rvalid_reg;
    assign res.dropped      = out_drop_reg;
    assign res.chunk_start  = out_cstart_reg;
    assign res.chunk_length = out_clen_reg;
    assign res.fill_count   = out_fill_reg;
    assign res.partial_bits = out_bits_reg;

endmodule

`default_nettype wire

FILE: src/bbrb_chk.sv
// port-level checker of the byte ring buffer and its bind
`default_nettype none
`include "bit_assembling_byte_ring_buffer_defines.svh"

module bbrb_chk
    import bbrb_pkg::*;
(
    input wire logic              clk,
    input wire logic              rst_n,
    input wire logic              cmd_valid,
    input wire logic              cmd_ready,
    input wire logic              res_valid,
    input wire logic              res_ready,
    input wire logic [BYTE_W-1:0] read_data,
    input wire logic              read_valid,
    input wire logic              dropped,
    input wire logic [BYTE_W-1:0] chunk_start,
    input wire logic [CLEN_W-1:0] chunk_length,
    input wire logic [FILL_W-1:0] fill_count,
    input wire logic [BITS_W-1:0] partial_bits
);

    // a stalled request side means a result is waiting
    `BBRB_ASSERT_IMP(a_stall_has_result, !cmd_ready, res_valid, "request stalled with no result")

    // no data byte without a successful pop
    `BBRB_ASSERT_IMP(a_rdata_zero, res_valid && !read_valid, read_data == '0, "read_data without pop")

    // a result comes from one command only
    `BBRB_ASSERT_IMP(a_one_kind, res_valid && (chunk_length != '0), !read_valid && !dropped, "mixed result")

    // a result held back keeps its payload
    `BBRB_ASSERT_NXT(a_hold, res_valid && !res_ready, res_valid && $stable(read_data) && $stable(read_valid) && $stable(dropped) && $stable(chunk_start) && $stable(chunk_length) && $stable(fill_count) && $stable(partial_bits), "result changed while stalled")

endmodule

bind bit_assembling_byte_ring_buffer bbrb_chk u_bbrb_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd_valid    (cmd.valid),
    .cmd_ready    (cmd.ready),
    .res_valid    (res.valid),
    .res_ready    (res.ready),
    .read_data    (res.read_data),
    .read_valid   (res.read_valid),
    .dropped      (res.dropped),
    .chunk_start  (res.chunk_start),
    .chunk_length (res.chunk_length),
    .fill_count   (res.fill_count),
    .partial_bits (res.partial_bits)
);

`default_nettype wire
